FILE: src/mf_pkg.sv
// shared types and constants for the edge-aware 3x3 median filter
// used by every module of the block except mf_ram; no dependencies
package mf_pkg;

	localparam int MAX_LINE = 1024;
	localparam int LINE_AW  = $clog2(MAX_LINE);
	localparam int PIX_W    = 8;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 16;
	localparam int ROW_W    = HEIGHT_W + 1;
	localparam int WIN_N    = 9;
	localparam int RANK_W   = 4;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int RESQ_DEPTH = 8;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [WIDTH_W-1:0]  LINE_MAX     = WIDTH_W'(MAX_LINE);
	localparam logic [PIX_W-1:0]    PIX_MAX      = '1;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_FLUSH = 1'b1
	} mode_t;

	// one slot of work for the back part
	typedef struct packed {
		logic [LINE_AW-1:0] x;
		logic [PIX_W-1:0]   bot;
		logic               emit;
		logic               last;
		logic               top_ok;
		logic               bot_ok;
		logic               left_ok;
		logic               right_ok;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] median;
		logic             last;
	} res_t;

endpackage

FILE: src/mf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mf_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/mf_cmdq.sv
// small command queue between the front and back parts
// depends on mf_pkg
module mf_cmdq import mf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output logic valid,
	output cmd_t rdata
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] head_q;
	logic [CMDQ_AW-1:0] tail_q;
	logic [CMDQ_AW:0]   count_q;

	assign full  = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				tail_q <= tail_q + 1'b1;
			end
			if (rd) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + (CMDQ_AW+1)'(wr) - (CMDQ_AW+1)'(rd);
		end
	end

endmodule

FILE: src/mf_resq.sv
// result queue that faces the receiver; space is reserved by the back part
// depends on mf_pkg
module mf_resq import mf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  res_t             wdata,
	input  logic             rd,
	output logic             empty,
	output res_t             rdata,
	output logic [RESQ_AW:0] count
);

	res_t               mem_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] head_q;
	logic [RESQ_AW-1:0] tail_q;
	logic [RESQ_AW:0]   count_q;
	logic               rd_ok;

	assign empty = (count_q == '0);
	assign rdata = mem_q[head_q];
	assign count = count_q;
	assign rd_ok = rd && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				tail_q <= tail_q + 1'b1;
			end
			if (rd_ok) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + (RESQ_AW+1)'(wr) - (RESQ_AW+1)'(rd_ok);
		end
	end

endmodule

FILE: src/mf_front.sv
// front part: tracks the raster position, drops stray flushes and tags each
// slot with its border flags; depends on mf_pkg
module mf_front import mf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [WIDTH_W-1:0]  line_len,
	input  logic [HEIGHT_W-1:0] frame_lines,
	input  logic                push,
	input  logic                q_full,
	input  logic                mode,
	input  logic [PIX_W-1:0]    pixel_in,
	output logic                q_wr,
	output cmd_t                q_data
);

	logic [LINE_AW-1:0]  col_q;
	logic [ROW_W-1:0]    row_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [ROW_W-1:0]    h_ext;
	logic [ROW_W-1:0]    h_plus1;
	logic [LINE_AW-1:0]  col_w;
	logic [ROW_W-1:0]    row_w;
	logic [LINE_AW-1:0]  col_p;
	logic [ROW_W-1:0]    row_p;
	logic [WIDTH_W-1:0]  col_inc;
	logic                is_pixel;
	logic                ignore;
	logic                last;
	logic                accept;
	logic                col_nz;

	always_comb begin
		w_eff = line_len;
		if (line_len < WIDTH_W'(2)) begin
			w_eff = WIDTH_W'(2);
		end else if (line_len > LINE_MAX) begin
			w_eff = LINE_MAX;
		end
		h_eff = (frame_lines < HEIGHT_W'(2)) ? HEIGHT_W'(2) : frame_lines;
		h_ext   = ROW_W'(h_eff);
		h_plus1 = h_ext + 1'b1;

		// a column left past the line end by a width change starts the next row
		if (WIDTH_W'(col_q) >= w_eff) begin
			col_w = '0;
			row_w = row_q + 1'b1;
		end else begin
			col_w = col_q;
			row_w = row_q;
		end
		// past the frame's last slot: start over
		if (row_w > h_plus1 || (row_w == h_plus1 && col_w != '0)) begin
			col_p = '0;
			row_p = '0;
		end else begin
			col_p = col_w;
			row_p = row_w;
		end

		col_nz   = (col_p != '0);
		is_pixel = (row_p < h_ext);
		ignore   = is_pixel && (mode == MODE_FLUSH);
		last     = (row_p == h_plus1) && !col_nz;
		accept   = push && !q_full;
		col_inc  = WIDTH_W'(col_p) + 1'b1;

		q_wr            = accept && !ignore;
		q_data.x        = col_p;
		q_data.bot      = is_pixel ? pixel_in : '0;
		q_data.emit     = (row_p >= ROW_W'(2)) || (row_p == ROW_W'(1) && col_nz);
		q_data.last     = last;
		q_data.top_ok   = col_nz ? (row_p >= ROW_W'(2)) : (row_p >= ROW_W'(3));
		q_data.bot_ok   = col_nz ? (row_p < h_ext) : (row_p < h_plus1);
		q_data.left_ok  = !col_nz || (col_p >= LINE_AW'(2));
		q_data.right_ok = col_nz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ignore) begin
				col_q <= col_p;
				row_q <= row_p;
			end else if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= row_p + 1'b1;
			end else begin
				col_q <= col_inc[LINE_AW-1:0];
				row_q <= row_p;
			end
		end
	end

endmodule

FILE: src/mf_back.sv
// back part: line stores, 3x3 window and a rank-based median pipeline
// depends on mf_pkg and mf_ram
module mf_back import mf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_rd,
	input  logic [RESQ_AW:0] res_count,
	output logic             res_wr,
	output res_t             res
);

	// stage 1: line store read
	logic               v_s1;
	cmd_t               cmd_s1;
	logic               byp_s1;
	logic [PIX_W-1:0]   byp_up_s1;
	logic [PIX_W-1:0]   byp_mid_s1;
	logic [PIX_W-1:0]   up_rdata;
	logic [PIX_W-1:0]   mid_rdata;
	logic [PIX_W-1:0]   up_eff;
	logic [PIX_W-1:0]   mid_eff;

	// stage 2: window
	logic [PIX_W-1:0]   win_q [WIN_N];
	logic               v_s2;
	logic               last_s2;
	logic [3:0]         ok_s2;

	// stage 3: masked values and pairwise order
	logic               v_s3;
	logic               last_s3;
	logic [PIX_W-1:0]   val_s3 [WIN_N];
	logic [WIN_N-1:0]   ahead_s3 [WIN_N];
	logic [RANK_W-1:0]  klo_s3;
	logic [RANK_W-1:0]  khi_s3;

	// stage 4: ranks
	logic               v_s4;
	logic               last_s4;
	logic [PIX_W-1:0]   val_s4 [WIN_N];
	logic [RANK_W-1:0]  rank_s4 [WIN_N];
	logic [RANK_W-1:0]  klo_s4;
	logic [RANK_W-1:0]  khi_s4;

	logic [RESQ_AW+1:0] reserved;
	logic [PIX_W-1:0]   val_c [WIN_N];
	logic [WIN_N-1:0]   ahead_c [WIN_N];
	logic [RANK_W-1:0]  klo_c;
	logic [RANK_W-1:0]  khi_c;
	logic [2:0]         ok_cnt;
	logic [PIX_W-1:0]   lo_c;
	logic [PIX_W-1:0]   hi_c;
	logic [PIX_W:0]     sum_c;

	// take a slot only when its result is sure to find room
	assign reserved = (RESQ_AW+2)'(res_count) + (RESQ_AW+2)'(v_s1) + (RESQ_AW+2)'(v_s2)
		+ (RESQ_AW+2)'(v_s3) + (RESQ_AW+2)'(v_s4);
	assign cmd_rd = cmd_valid && (reserved < (RESQ_AW+2)'(RESQ_DEPTH));

	mf_ram #(.DATA_W(PIX_W), .DEPTH(MAX_LINE)) u_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (cmd_s1.x),
		.wdata (mid_eff),
		.re    (cmd_rd),
		.raddr (cmd.x),
		.rdata (up_rdata)
	);

	mf_ram #(.DATA_W(PIX_W), .DEPTH(MAX_LINE)) u_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (cmd_s1.x),
		.wdata (cmd_s1.bot),
		.re    (cmd_rd),
		.raddr (cmd.x),
		.rdata (mid_rdata)
	);

	// same column read while it is being written (frame wrap): forward
	assign up_eff  = byp_s1 ? byp_up_s1 : up_rdata;
	assign mid_eff = byp_s1 ? byp_mid_s1 : mid_rdata;

	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			cmd_s1     <= cmd;
			byp_s1     <= v_s1 && (cmd_s1.x == cmd.x);
			byp_up_s1  <= mid_eff;
			byp_mid_s1 <= cmd_s1.bot;
		end
		if (v_s1) begin
			last_s2 <= cmd_s1.last;
			ok_s2   <= {cmd_s1.top_ok, cmd_s1.bot_ok, cmd_s1.left_ok, cmd_s1.right_ok};
		end
		if (v_s2) begin
			last_s3  <= last_s2;
			val_s3   <= val_c;
			ahead_s3 <= ahead_c;
			klo_s3   <= klo_c;
			khi_s3   <= khi_c;
		end
		if (v_s3) begin
			last_s4 <= last_s3;
			val_s4  <= val_s3;
			klo_s4  <= klo_s3;
			khi_s4  <= khi_s3;
			for (int i = 0; i < WIN_N; i++) begin
				rank_s4[i] <= RANK_W'($countones(ahead_s3[i]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < WIN_N; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			v_s1 <= cmd_rd;
			v_s2 <= v_s1 && cmd_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s1) begin
				// rows top to bottom, columns oldest to newest
				for (int r = 0; r < 3; r++) begin
					win_q[3*r]   <= win_q[3*r+1];
					win_q[3*r+1] <= win_q[3*r+2];
				end
				win_q[2] <= up_eff;
				win_q[5] <= mid_eff;
				win_q[8] <= cmd_s1.bot;
			end
		end
	end

	// outside neighbours read as the maximum so they sort to the end
	always_comb begin
		ok_cnt = 3'(ok_s2[3]) + 3'(ok_s2[2]) + 3'(ok_s2[1]) + 3'(ok_s2[0]);
		case (ok_cnt)
			3'd4: begin
				klo_c = RANK_W'(4);
				khi_c = RANK_W'(4);
			end
			3'd3: begin
				klo_c = RANK_W'(2);
				khi_c = RANK_W'(3);
			end
			default: begin
				klo_c = RANK_W'(1);
				khi_c = RANK_W'(2);
			end
		endcase
		for (int i = 0; i < WIN_N; i++) begin
			if ((i < 3 && !ok_s2[3]) || (i >= 6 && !ok_s2[2]) ||
			    ((i % 3) == 0 && !ok_s2[1]) || ((i % 3) == 2 && !ok_s2[0])) begin
				val_c[i] = PIX_MAX;
			end else begin
				val_c[i] = win_q[i];
			end
		end
		// ahead_c[i][j]: element j sorts before element i, ties by position
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				if (j == i) begin
					ahead_c[i][j] = 1'b0;
				end else if (j < i) begin
					ahead_c[i][j] = (val_c[j] <= val_c[i]);
				end else begin
					ahead_c[i][j] = (val_c[j] < val_c[i]);
				end
			end
		end
	end

	always_comb begin
		lo_c = '0;
		hi_c = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (rank_s4[i] == klo_s4) begin
				lo_c = lo_c | val_s4[i];
			end
			if (rank_s4[i] == khi_s4) begin
				hi_c = hi_c | val_s4[i];
			end
		end
		sum_c      = {1'b0, lo_c} + {1'b0, hi_c};
		res_wr     = v_s4;
		res.median = sum_c[PIX_W:1];
		res.last   = last_s4;
	end

endmodule

FILE: src/median_filter_3x3_edge_aware_top.sv
// 3x3 edge-aware median filter: configuration registers and the wiring of
// front part, command queue, back part and result queue; depends on mf_pkg
//
// Usage:
//   Pixels enter in raster order through push/full with mode and pixel_in;
//   mode 1 is a flush tick. A frame of W*H pixels is followed by W+1 flush
//   ticks, and the result for each pixel (median_out, frame_last) leaves
//   through empty/pop one line plus one pixel of input later. Flush ticks
//   that arrive before the frame is complete are dropped.
//   Geometry is set through the APB port: line length at 0x0, line count
//   at 0x4; write it only while the filter is idle.
//   Throughput is one item per clock while full is low. The item that
//   completes a window passes through the command queue, the line store
//   read, the window and the rank-based median stages before its result
//   reaches the ports.
//   When the receiver stalls, results collect in an 8-entry queue; the back
//   part holds further work in the 4-entry command queue and full rises once
//   that is used up. Reset empties both queues, returns to the frame start
//   and restores 640x480; line store contents are left as they are.
module median_filter_3x3_edge_aware_top import mf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [PIX_W-1:0]  pixel_in,
	output logic              empty,
	input  logic              pop,
	output logic [PIX_W-1:0]  median_out,
	output logic              frame_last
);

	logic [WIDTH_W-1:0]  line_len_q;
	logic [HEIGHT_W-1:0] frame_lines_q;
	reg_idx_t            reg_sel;
	logic                q_wr;
	cmd_t                q_wdata;
	logic                q_rd;
	logic                q_valid;
	cmd_t                q_rdata;
	logic [RESQ_AW:0]    res_count;
	logic                res_wr;
	res_t                res_wdata;
	res_t                res_head;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q    <= WIDTH_RESET;
			frame_lines_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_WIDTH:  line_len_q    <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: frame_lines_q <= pwdata[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = CFG_DW'(line_len_q);
			REG_HEIGHT: prdata = CFG_DW'(frame_lines_q);
			default:    prdata = '0;
		endcase
	end

	mf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_len    (line_len_q),
		.frame_lines (frame_lines_q),
		.push        (push),
		.q_full      (full),
		.mode        (mode),
		.pixel_in    (pixel_in),
		.q_wr        (q_wr),
		.q_data      (q_wdata)
	);

	mf_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (full),
		.rd     (q_rd),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_rdata),
		.cmd_rd    (q_rd),
		.res_count (res_count),
		.res_wr    (res_wr),
		.res       (res_wdata)
	);

	mf_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_wdata),
		.rd     (pop),
		.empty  (empty),
		.rdata  (res_head),
		.count  (res_count)
	);

	assign median_out = res_head.median;
	assign frame_last = res_head.last;

endmodule

FILE: verif/tb_median_filter_3x3_edge_aware_top.sv
// self-checking testbench for the edge-aware 3x3 median filter: streams frames through
// the push/pop queues and checks every result against an in-bench filter model
// depends on mf_pkg and median_filter_3x3_edge_aware_top
`timescale 1ns / 100ps

module tb_median_filter_3x3_edge_aware_top;
	import mf_pkg::*;

	localparam int SETTLE_CYCLES = 16;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              push = 1'b0;
	logic              full;
	logic              mode = 1'b0;
	logic [PIX_W-1:0]  pixel_in = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [PIX_W-1:0]  median_out;
	logic              frame_last;

	// filter model state
	logic [WIDTH_W-1:0]  cfg_width = WIDTH_RESET;
	logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
	logic [PIX_W-1:0]    line_upper [MAX_LINE];
	logic [PIX_W-1:0]    line_middle [MAX_LINE];
	logic [PIX_W-1:0]    win [3][3];
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;
	res_t                median_q [$];

	int mismatch_cnt = 0;
	int requests_taken = 0;
	int send_idle_pct = 27;
	int recv_idle_pct = 84;

	median_filter_3x3_edge_aware_top DUT (.*);

	always #10 clk = ~clk;

	initial begin
		foreach (win[r, c]) win[r][c] = '0;
		foreach (line_upper[i]) begin
			line_upper[i] = '0;
			line_middle[i] = '0;
		end
	end

	function automatic int unsigned eff_width();
		if (cfg_width < 2) return 2;
		if (cfg_width > MAX_LINE) return MAX_LINE;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height < 2) ? 2 : cfg_height;
	endfunction

	function automatic longint unsigned frame_pixels();
		longint unsigned n;
		n = eff_width();
		return n * eff_height();
	endfunction

	// slot the next request will land on, without touching the state
	function automatic longint unsigned next_slot();
		int unsigned w;
		longint unsigned c, r, p;
		w = eff_width();
		c = col_pos;
		r = row_pos;
		if (c >= w) begin
			c = 0;
			r++;
		end
		p = r * w + c;
		if (p > frame_pixels() + w) p = 0;
		return p;
	endfunction

	// advance the filter model by one request; returns 0 when it is dropped
	function automatic bit filter_step(mode_t m, logic [PIX_W-1:0] px);
		int unsigned w, h, x, cr, cc, r_lo, r_hi, c_lo, c_hi, n, t, j;
		longint unsigned pix, last_slot, p, centre;
		logic [PIX_W-1:0] bot;
		int unsigned vals [9];
		res_t res;
		w = eff_width();
		h = eff_height();
		pix = frame_pixels();
		last_slot = pix + w;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		p = row_pos;
		p = p * w + col_pos;
		if (p > last_slot) begin
			row_pos = 0;
			col_pos = 0;
			p = 0;
		end
		if (p < pix && m == MODE_FLUSH) return 1'b0;
		x = col_pos;
		bot = (p < pix) ? px : '0;
		for (int wr = 0; wr < 3; wr++) begin
			win[wr][0] = win[wr][1];
			win[wr][1] = win[wr][2];
		end
		win[0][2] = line_upper[x];
		win[1][2] = line_middle[x];
		win[2][2] = bot;
		line_upper[x] = line_middle[x];
		line_middle[x] = bot;
		if (p >= w + 1) begin
			centre = p - w - 1;
			cr = int'(centre / w);
			cc = int'(centre % w);
			// clip the window at the frame border
			r_lo = (cr > 0) ? 0 : 1;
			r_hi = (cr + 1 < h) ? 2 : 1;
			c_lo = (cc > 0) ? 0 : 1;
			c_hi = (cc + 1 < w) ? 2 : 1;
			n = 0;
			for (int wr = r_lo; wr <= r_hi; wr++) begin
				for (int wc = c_lo; wc <= c_hi; wc++) begin
					vals[n] = win[wr][wc];
					n++;
				end
			end
			for (int i = 1; i < n; i++) begin
				t = vals[i];
				j = i;
				while (j > 0 && vals[j - 1] > t) begin
					vals[j] = vals[j - 1];
					j--;
				end
				vals[j] = t;
			end
			// even count: floor of the mean of the middle pair
			if (n % 2 != 0) res.median = PIX_W'(vals[n / 2]);
			else res.median = PIX_W'((vals[n / 2 - 1] + vals[n / 2]) >> 1);
			res.last = (p == last_slot);
			median_q.push_back(res);
		end
		if (p == last_slot) begin
			row_pos = 0;
			col_pos = 0;
		end else begin
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return PIX_MAX;
			2, 3, 4: return PIX_W'(126 + $urandom_range(3));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic push_request(mode_t m, logic [PIX_W-1:0] px);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		mode <= m;
		pixel_in <= px;
		do @(posedge clk); while (full);
		if (filter_step(m, px)) requests_taken++;
	endtask

	// hold off until every expected result is out and the pipe has settled
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH: cfg_width = val[WIDTH_W-1:0];
			REG_HEIGHT: cfg_height = val[HEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_reg(reg_idx_t idx, output logic [CFG_DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CFG_AW'(4 * int'(idx));
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		val = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h);
		write_reg(REG_WIDTH, CFG_DW'(w));
		write_reg(REG_HEIGHT, CFG_DW'(h));
	endtask

	// run up to the given number of slots (0: to the end of the frame);
	// noise adds dropped flushes inside the frame and pixels during the drain
	task automatic feed_frame(int unsigned slots, int unsigned noise_pct);
		longint unsigned p;
		int unsigned done_n;
		bit fin;
		done_n = 0;
		fin = 1'b0;
		while (!fin && (slots == 0 || done_n < slots)) begin
			p = next_slot();
			fin = (p == frame_pixels() + eff_width());
			if (p < frame_pixels()) begin
				if ($urandom_range(99) < noise_pct) begin
					push_request(MODE_FLUSH, pick_pixel());
				end else begin
					push_request(MODE_PIXEL, pick_pixel());
					done_n++;
				end
			end else begin
				push_request(($urandom_range(99) < noise_pct) ? MODE_PIXEL : MODE_FLUSH,
					pick_pixel());
				done_n++;
			end
		end
	endtask

	// 640x480 out of reset, then shrink to 2x2 partway through the first line
	task automatic test_reset_geometry();
		logic [CFG_DW-1:0] rd_val;
		read_reg(REG_WIDTH, rd_val);
		if (rd_val !== CFG_DW'(WIDTH_RESET))
			report_mismatch($sformatf("width register %0d, want %0d", rd_val, WIDTH_RESET));
		read_reg(REG_HEIGHT, rd_val);
		if (rd_val !== CFG_DW'(HEIGHT_RESET))
			report_mismatch($sformatf("height register %0d, want %0d", rd_val, HEIGHT_RESET));
		repeat (5) push_request(MODE_PIXEL, pick_pixel());
		set_geometry(2, 2);
		feed_frame(0, 0);
	endtask

	task automatic test_directed_frames();
		logic [PIX_W-1:0] corner_px [4];
		logic [PIX_W-1:0] grid_px [9];
		corner_px = '{8'hFF, 8'h00, 8'hFF, 8'h01};
		grid_px = '{8'h00, 8'hFF, 8'h07, 8'h80, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h81};
		// both registers below range, used as 2x2: every pixel is a corner
		set_geometry(0, 1);
		push_request(MODE_PIXEL, corner_px[0]);
		push_request(MODE_FLUSH, 8'hA5);
		for (int i = 1; i < 4; i++) push_request(MODE_PIXEL, corner_px[i]);
		push_request(MODE_FLUSH, 8'h5A);
		push_request(MODE_PIXEL, 8'h77);
		push_request(MODE_FLUSH, 8'h00);
		// corners, edges and one interior pixel
		set_geometry(3, 3);
		foreach (grid_px[i]) push_request(MODE_PIXEL, grid_px[i]);
		repeat (4) push_request(MODE_FLUSH, PIX_MAX);
	endtask

	task automatic test_geometry_change();
		// oversize width, tallest frame, then cut down partway through
		set_geometry(2047, 65535);
		feed_frame(40, 5);
		set_geometry(4, 1);
		feed_frame(0, 5);
		// shrinking the height past the current position restarts the frame
		set_geometry(2, 65535);
		feed_frame(20, 0);
		set_geometry(2, 0);
		feed_frame(0, 0);
	endtask

	task automatic test_random_frames(int unsigned n);
		int unsigned goal, w, h, r;
		goal = requests_taken + n;
		while (requests_taken < goal) begin
			r = $urandom_range(99);
			if (r < 75) begin
				w = $urandom_range(8, 2);
				h = $urandom_range(5, 2);
			end else if (r < 92) begin
				w = $urandom_range(40, 9);
				h = $urandom_range(3, 2);
			end else begin
				w = $urandom_range(2, 0);
				h = $urandom_range(1, 0);
			end
			set_geometry(w, h);
			// some frames are cut short and the next geometry lands mid-frame
			if ($urandom_range(99) < 20)
				feed_frame($urandom_range(int'(frame_pixels()) + eff_width(), 1), 8);
			else
				feed_frame(0, 8);
		end
	endtask

	always @(negedge clk) pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && pop && !empty) begin
			if (median_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result median %0d last %0b",
					median_out, frame_last));
			end else begin
				want = median_q.pop_front();
				if (median_out !== want.median)
					report_mismatch($sformatf("median_out %0d, want %0d",
						median_out, want.median));
				if (frame_last !== want.last)
					report_mismatch($sformatf("frame_last %0b, want %0b",
						frame_last, want.last));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_directed_frames();
		test_geometry_change();
		test_random_frames(170);
		send_idle_pct = 84;
		recv_idle_pct = 27;
		test_random_frames(170);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(170);
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_median_filter_3x3_edge_aware_top: clean");
		else
			$display("tb_median_filter_3x3_edge_aware_top: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_median_filter_3x3_edge_aware_top: errors");
		$finish;
	end

endmodule
